FILE: sv/mssync_pkg.sv
// ----------------------------------------------------------------------------
// mssync_pkg
// Shared widths and constants of the multi-stream time synchroniser.
// ----------------------------------------------------------------------------
package mssync_pkg;

  localparam int TIME_W = 31;
  localparam int PORT_TAG_W = 16;
  localparam int SID_W = 2;
  localparam int CNT_W = 3;
  localparam logic [TIME_W-1:0] TIME_MAX = 31'h7FFF_FFFF;

endpackage

FILE: sv/mssync_ram.sv
// ----------------------------------------------------------------------------
// mssync_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mssync_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/multi_stream_time_synchronizer_unit.sv
// ----------------------------------------------------------------------------
// multi_stream_time_synchronizer_unit
// Buffers time-stamped tuples per stream in one RAM and releases them in
// event-time order whenever the streams holding a tuple match the stream count.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents
//  in_*     slave      one tuple: stream id, event time, tag
//  out_*    master     released, passed or dropped tuple; tlast ends a burst
//  cfg_*    write-only stream_count register
//
// Each stream's buffer is a circular region of the RAM with a head pointer
// and a fill count held in flip-flops. A sorted insert walks the buffer from
// its tail, reading and comparing each entry it moves. A release round first
// visits every stream to find the smallest head time, then visits them again
// and releases, stream by stream, every head tuple equal to that time. A
// tuple passed straight out or dropped never enters the RAM. Reset is
// synchronous and clears all control state; the RAM needs no clearing, as
// only entries below a stream's fill are read. A stalled output holds the
// whole sequencer, and one further result may wait in a staging register
// so that tlast can be set on the final one.
module multi_stream_time_synchronizer_unit
  import mssync_pkg::*;
#(
  parameter int STREAMS = 4,
  parameter int BUFFER_DEPTH = 8,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // stream_id, event_time, tuple_tag, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_stream, out_time, out_tag, zero fill
  output logic        out_tuser,  // dropped
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);

  localparam int TW = (TAG_BITS < PORT_TAG_W) ? TAG_BITS : PORT_TAG_W;
  localparam int SIW = $clog2(STREAMS);
  localparam int SW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = $clog2(STREAMS * BUFFER_DEPTH);
  localparam int ACW = $clog2(STREAMS + 1);
  localparam int EW = TIME_W + TW;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_INS_RD, S_INS_CMP, S_CHK,
    S_MIN_RD, S_MIN_CMP, S_REL_RD, S_REL_CMP, S_FLUSH
  } state_t;

  state_t state_r;

  logic [SID_W-1:0]  sid_r;
  logic [TIME_W-1:0] time_r;
  logic [TW-1:0]     tag_r;
  logic [SIW-1:0]    cur_r;
  logic [FW-1:0]     j_r;
  logic [TIME_W-1:0] min_r;
  logic [TIME_W-1:0] sync_r;
  logic [ACW-1:0]    active_r;
  logic [CNT_W-1:0]  count_r;
  logic [FW-1:0]     fill_r [STREAMS];
  logic [SW-1:0]     head_r [STREAMS];

  logic              pend_valid_r;
  logic [SIW-1:0]    pend_sid_r;
  logic [EW-1:0]     pend_ent_r;

  logic              out_valid_r;
  logic [55:0]       out_data_r;
  logic              out_drop_r;
  logic              out_last_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  logic [TIME_W-1:0] rd_time;
  logic [FW-1:0]     cur_fill;
  logic [SW-1:0]     cur_head;
  logic              out_free;
  logic              bad_sid;
  logic              last_stream;
  logic [STREAMS-1:0] nonempty;

  // Slot arithmetic: head plus offset wraps at most once.
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] h,
                                            input logic [FW-1:0] off);
    logic [SW+FW:0] sum;
    sum = (SW+FW+1)'(h) + (SW+FW+1)'(off);
    if (sum >= (SW+FW+1)'(BUFFER_DEPTH)) begin
      sum = sum - (SW+FW+1)'(BUFFER_DEPTH);
    end
    return SW'(sum);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [SIW-1:0] s,
                                            input logic [SW-1:0] slot);
    return AW'(32'(s) * BUFFER_DEPTH + 32'(slot));
  endfunction

  function automatic logic [55:0] pack_out(input logic [SIW-1:0] s,
                                           input logic [EW-1:0] e);
    return {7'd0, PORT_TAG_W'(e[TW-1:0]), e[EW-1:TW], SID_W'(s)};
  endfunction

  assign cur_fill    = fill_r[cur_r];
  assign cur_head    = head_r[cur_r];
  assign rd_time     = ram_rdata[EW-1:TW];
  assign out_free    = !out_valid_r || out_tready;
  assign bad_sid     = 32'(sid_r) >= 32'(STREAMS);
  assign last_stream = cur_r == SIW'(STREAMS - 1);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_drop_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    for (int i = 0; i < STREAMS; i++) begin
      nonempty[i] = fill_r[i] != '0;
    end
  end

  // RAM access: inserts shift entries towards the tail, scans read heads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(cur_r, slot_of(cur_head, j_r));
    ram_wdata = {time_r, tag_r};
    ram_re    = 1'b0;
    ram_raddr = addr_of(cur_r, cur_head);
    case (state_r)
      S_INS_RD: begin
        if (j_r == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_of(cur_r, slot_of(cur_head, j_r - FW'(1)));
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (rd_time > time_r) begin
          ram_wdata = ram_rdata;
        end
      end
      S_MIN_RD, S_REL_RD: begin
        ram_re = cur_fill != '0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  mssync_ram #(
    .WIDTH (EW),
    .DEPTH (STREAMS * BUFFER_DEPTH)
  ) u_buf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sync_r       <= '0;
      active_r     <= '0;
      count_r      <= CNT_W'(4);
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cur_r        <= '0;
      for (int i = 0; i < STREAMS; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sid_r   <= in_tdata[1:0];
            time_r  <= in_tdata[32:2];
            tag_r   <= in_tdata[33+TW-1:33];
            cur_r   <= SIW'(in_tdata[1:0]);
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (time_r <= sync_r || bad_sid ||
              cur_fill >= FW'(BUFFER_DEPTH)) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_data_r  <= {7'd0, PORT_TAG_W'(tag_r), time_r, sid_r};
              out_drop_r  <= !(time_r <= sync_r);
              out_last_r  <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else begin
            if (cur_fill == '0) begin
              active_r <= active_r + ACW'(1);
            end
            j_r     <= cur_fill;
            state_r <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (j_r == '0) begin
            fill_r[cur_r] <= cur_fill + FW'(1);
            state_r       <= S_CHK;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_time > time_r) begin
            j_r     <= j_r - FW'(1);
            state_r <= S_INS_RD;
          end else begin
            fill_r[cur_r] <= cur_fill + FW'(1);
            state_r       <= S_CHK;
          end
        end
        S_CHK: begin
          if (32'(active_r) == 32'(count_r)) begin
            min_r   <= TIME_MAX;
            cur_r   <= '0;
            state_r <= S_MIN_RD;
          end else begin
            state_r <= S_FLUSH;
          end
        end
        S_MIN_RD: begin
          if (cur_fill != '0) begin
            state_r <= S_MIN_CMP;
          end else if (last_stream) begin
            sync_r  <= min_r;
            cur_r   <= '0;
            state_r <= S_REL_RD;
          end else begin
            cur_r <= cur_r + SIW'(1);
          end
        end
        S_MIN_CMP: begin
          if (last_stream) begin
            sync_r  <= (rd_time < min_r) ? rd_time : min_r;
            min_r   <= (rd_time < min_r) ? rd_time : min_r;
            cur_r   <= '0;
            state_r <= S_REL_RD;
          end else begin
            if (rd_time < min_r) begin
              min_r <= rd_time;
            end
            cur_r   <= cur_r + SIW'(1);
            state_r <= S_MIN_RD;
          end
        end
        S_REL_RD: begin
          if (cur_fill != '0) begin
            state_r <= S_REL_CMP;
          end else if (last_stream) begin
            state_r <= S_CHK;
          end else begin
            cur_r <= cur_r + SIW'(1);
          end
        end
        S_REL_CMP: begin
          if (rd_time == min_r) begin
            if (!pend_valid_r || out_free) begin
              if (pend_valid_r) begin
                out_valid_r <= 1'b1;
                out_data_r  <= pack_out(pend_sid_r, pend_ent_r);
                out_drop_r  <= 1'b0;
                out_last_r  <= 1'b0;
              end
              pend_valid_r  <= 1'b1;
              pend_sid_r    <= cur_r;
              pend_ent_r    <= ram_rdata;
              head_r[cur_r] <= slot_of(cur_head, FW'(1));
              fill_r[cur_r] <= cur_fill - FW'(1);
              if (cur_fill == FW'(1)) begin
                active_r <= active_r - ACW'(1);
              end
              state_r <= S_REL_RD;
            end
          end else if (last_stream) begin
            state_r <= S_CHK;
          end else begin
            cur_r   <= cur_r + SIW'(1);
            state_r <= S_REL_RD;
          end
        end
        S_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= pack_out(pend_sid_r, pend_ent_r);
            out_drop_r   <= 1'b0;
            out_last_r   <= 1'b1;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A new tuple is only taken once the staged result has gone out.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("staged result left behind on return to idle");

  // Between tuples the active count matches the non-empty buffers.
  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> 32'(active_r) == $countones(nonempty))
    else $error("active stream count out of step with buffer fills");

  // A rejected tuple is always a burst of its own.
  a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drop_r |-> out_last_r)
    else $error("dropped tuple without tlast");

  // A staged tuple never lies beyond the sync time; a later round may have
  // moved the sync time on while it waits.
  a_release_time: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> pend_ent_r[EW-1:TW] <= sync_r)
    else $error("staged tuple time lies beyond sync time");

endmodule

FILE: test/multi_stream_time_synchronizer_unit_test.sv
// ----------------------------------------------------------------------------
// multi_stream_time_synchronizer_unit_test
// Self-checking bench for the synchroniser: a predictor in the bench tracks
// every stream buffer, the sync time and the active count, and each
// transaction on the result channel is checked against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_stream_time_synchronizer_unit_test;
  import mssync_pkg::*;

  localparam int NSTR  = 4;
  localparam int DEPTH = 8;
  localparam int DRAIN = 200;  // cycles allowed for a silent insert to finish

  typedef struct packed {
    logic [SID_W-1:0]      sid;
    logic [TIME_W-1:0]     tstamp;
    logic [PORT_TAG_W-1:0] tag;
    logic                  dropped;
    logic                  last;
  } tuple_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // stream_id, event_time, tuple_tag, zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // out_stream, out_time, out_tag, zero fill
  logic        out_tuser;  // dropped
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [2:0]  cfg_wr_data;

  multi_stream_time_synchronizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mirror of the block's state.
  logic [TIME_W-1:0]     buf_ts  [NSTR][DEPTH];
  logic [PORT_TAG_W-1:0] buf_tg  [NSTR][DEPTH];
  int                    buf_cnt [NSTR];
  logic [TIME_W-1:0]     sync_ts;
  int                    live_streams;
  int                    need_streams;

  tuple_res_t released_q[$];
  int  errors;
  int  sent;
  int  checked;
  int  drops_seen;
  int  send_idle;
  int  recv_idle;

  // Works out the tuples one accepted input releases and queues them.
  task automatic predict_release(input logic [SID_W-1:0] sid,
                                 input logic [TIME_W-1:0] ts,
                                 input logic [PORT_TAG_W-1:0] tg);
    tuple_res_t burst[$];
    tuple_res_t r;
    int pos;
    int k;
    int n;
    logic [TIME_W-1:0] low;
    if (ts <= sync_ts) begin
      released_q.push_back('{sid, ts, tg, 1'b0, 1'b1});
      return;
    end
    if (buf_cnt[sid] >= DEPTH) begin
      released_q.push_back('{sid, ts, tg, 1'b1, 1'b1});
      return;
    end
    // Sorted insert; equal times go behind stored ones.
    if (buf_cnt[sid] == 0) live_streams++;
    pos = buf_cnt[sid];
    while (pos > 0 && buf_ts[sid][pos-1] > ts) begin
      buf_ts[sid][pos] = buf_ts[sid][pos-1];
      buf_tg[sid][pos] = buf_tg[sid][pos-1];
      pos--;
    end
    buf_ts[sid][pos] = ts;
    buf_tg[sid][pos] = tg;
    buf_cnt[sid]++;
    // Release rounds while every required stream holds a tuple.
    while (live_streams == need_streams) begin
      low = TIME_MAX;
      for (int s = 0; s < NSTR; s++)
        if (buf_cnt[s] != 0 && buf_ts[s][0] < low) low = buf_ts[s][0];
      sync_ts = low;
      for (int s = 0; s < NSTR; s++) begin
        if (buf_cnt[s] == 0) continue;
        k = 0;
        while (k < buf_cnt[s] && buf_ts[s][k] == low) begin
          r = '{s[SID_W-1:0], buf_ts[s][k], buf_tg[s][k], 1'b0, 1'b0};
          burst.push_back(r);
          k++;
        end
        n = buf_cnt[s] - k;
        for (int j = 0; j < n; j++) begin
          buf_ts[s][j] = buf_ts[s][j+k];
          buf_tg[s][j] = buf_tg[s][j+k];
        end
        buf_cnt[s] = n;
        if (n == 0) live_streams--;
      end
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) released_q.push_back(burst[i]);
  endtask

  // Drives one tuple and holds it until accepted. Valid is left high so a
  // following send does not lower and raise it in the same step.
  task automatic send_tuple(input logic [SID_W-1:0] sid,
                            input logic [TIME_W-1:0] ts,
                            input logic [PORT_TAG_W-1:0] tg);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, tg, ts, sid};
    do @(posedge clk); while (!in_tready);
    predict_release(sid, ts, tg);
    sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (released_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_stream_count(input logic [2:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    need_streams = value;
  endtask

  // A time a little past the current sync time, so tuples get buffered.
  function automatic logic [TIME_W-1:0] ahead(input int off);
    return TIME_W'(sync_ts + off);
  endfunction

  // Result channel: random back-pressure and an in-order check.
  always @(posedge clk) begin
    tuple_res_t want;
    tuple_res_t got;
    out_tready <= ($urandom_range(99) >= recv_idle);
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[1:0], out_tdata[32:2], out_tdata[48:33], out_tuser, out_tlast};
      checked++;
      if (got.dropped) drops_seen++;
      if (released_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %p", $time, got);
      end else begin
        want = released_q.pop_front();
        if (got !== want || out_tdata[55:49] !== 7'd0) begin
          errors++;
          $display("%0t: mismatch, expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  // With a single required stream every buffered tuple leaves at once;
  // tuples at or before the sync time pass straight through.
  task automatic test_pass_through();
    write_stream_count(3'd1);
    send_tuple(2'd0, '0, 16'h0000);
    send_tuple(2'd3, '0, 16'hFFFF);
    send_tuple(2'd1, ahead(5), 16'h1234);
    send_tuple(2'd2, ahead(0), 16'hA5A5);
    send_tuple(2'd3, ahead(1), 16'h5A5A);
  endtask

  // Under a count of two one tuple is buffered on stream 1; the rest lie at or before the sync time.
  task automatic test_equal_times();
    write_stream_count(3'd2);
    send_tuple(2'd1, ahead(3), 16'h0011);
    send_tuple(2'd1, ahead(0), 16'h0022);
    send_tuple(2'd1, ahead(-1), 16'h0033);
    send_tuple(2'd0, ahead(-2), 16'h0044);
  endtask

  // With an unreachable count one stream fills; the ninth tuple is dropped.
  task automatic test_full_buffer();
    write_stream_count(3'd7);
    for (int i = 0; i < DEPTH + 1; i++)
      send_tuple(2'd3, ahead(9 - i), PORT_TAG_W'(16'h0100 + i));
  endtask

  // Count of zero holds everything; a count below the active count holds too,
  // until the count is met again.
  task automatic test_count_changes();
    write_stream_count(3'd0);
    send_tuple(2'd0, ahead(4), 16'h0200);
    send_tuple(2'd1, ahead(6), 16'h0201);
    write_stream_count(3'd2);
    send_tuple(2'd2, ahead(2), 16'h0202);
    write_stream_count(3'd4);
    send_tuple(2'd1, ahead(1), 16'h0203);
  endtask

  // Mostly tuples a little ahead of the sync time, so the buffers fill and
  // release; some late ones and a few arbitrary times mixed in.
  task automatic test_random(input int count, input logic [2:0] streams,
                             input int s_idle, input int r_idle);
    logic [TIME_W-1:0] ts;
    send_idle = s_idle;
    recv_idle = r_idle;
    write_stream_count(streams);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0:       ts = TIME_W'($urandom());
        1, 2:    ts = TIME_W'(sync_ts - $urandom_range(3));
        default: ts = ahead($urandom_range(1, 24));
      endcase
      send_tuple(SID_W'($urandom_range(3)), ts, PORT_TAG_W'($urandom()));
      if (i == count / 2 && streams == 3'd4) wait_idle();
      if ($urandom_range(49) == 0) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // The largest time comes last, since it leaves every later tuple late.
  task automatic test_time_max();
    write_stream_count(3'd1);
    send_tuple(2'd2, TIME_MAX, 16'hFFFF);
    send_tuple(2'd1, TIME_MAX, 16'h8001);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    sent = 0;
    checked = 0;
    drops_seen = 0;
    send_idle = 0;
    recv_idle = 0;
    foreach (buf_cnt[s]) buf_cnt[s] = 0;
    sync_ts = '0;
    live_streams = 0;
    need_streams = 4;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pass_through();
    test_equal_times();
    test_full_buffer();
    test_count_changes();
    test_random(60, 3'd4, 27, 54);
    test_random(60, 3'd3, 54, 27);
    test_random(60, 3'd4, 0, 0);
    test_time_max();
    wait_idle();

    $display("Sent %0d tuples over stream counts 0 to 7, checked %0d results (%0d dropped).",
             sent, checked, drops_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", released_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: multi_stream_time_synchronizer_unit.f
sv/mssync_pkg.sv
sv/mssync_ram.sv
sv/multi_stream_time_synchronizer_unit.sv
test/multi_stream_time_synchronizer_unit_test.sv
